// ===== rtl/dspm_pkg.sv =====
package dspm_pkg;

   localparam int REQ_W    = 2;
   localparam int POS_W    = 6;
   localparam int SYMBOL_W = 8;
   localparam int LEN_W    = 7;

   localparam logic [SYMBOL_W-1:0] SYM_DOT  = 8'd46;
   localparam logic [SYMBOL_W-1:0] SYM_STAR = 8'd42;

   typedef enum logic [REQ_W-1:0] {
      REQ_WRITE = 2'd0,
      REQ_BYTE  = 2'd1,
      REQ_END   = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      PASS_BUILD = 2'd0,
      PASS_SWEEP = 2'd1,
      PASS_SCAN  = 2'd2
   } pass_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_BUILD  = 3'd1,
      ST_SWEEP  = 3'd2,
      ST_SCAN   = 3'd3,
      ST_REPORT = 3'd4
   } state_type;

   typedef struct packed {
      logic          step;
      pass_mode_type mode;
      logic          wr_en;
      logic          load_byte;
   } cmd_type;

   typedef struct packed {
      logic last_step;
   } status_type;

endpackage

// ===== rtl/dot_star_pattern_match_unit.sv =====
// whole-string matcher for patterns with '.' (any byte) and 'x*' (zero or more)
//
// req channel (req_valid/req_ready) carries three kinds of item on req_type:
//   write  - stores req_symbol at req_pattern_pos
//   byte   - one subject byte; sweeps every pattern position, one a cycle;
//            for the first byte of a subject the empty-subject row is
//            rebuilt first
//   end    - closes the subject; one pass reads out the final match bit,
//            then rsp_valid rises once the output register is free
// the row sweep is serial: the star term depends on the entry two
// positions back in the same row, so one position is resolved per cycle
// one item is worked at a time; req_ready is high only between passes
// rsp channel holds the result in an output register; a stalled receiver does
// not block writes or bytes; a following end item is taken, then holds the
// block in its report step until the earlier result is taken
// csr channel writes pattern_length at any time the block is idle
// reset: pattern_length to zero, no subject open, no result pending;
// pattern symbols are undefined until written, no clearing pass
module dot_star_pattern_match_unit #(
   parameter int MAX_PATTERN = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [dspm_pkg::REQ_W-1:0]      req_type,
   input  logic [dspm_pkg::POS_W-1:0]      req_pattern_pos,
   input  logic [dspm_pkg::SYMBOL_W-1:0]   req_symbol,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_matched,
   // length register write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dspm_pkg::LEN_W-1:0]      csr_pattern_length
);

   dspm_pkg::cmd_type    cmd;
   dspm_pkg::status_type status;

   logic [dspm_pkg::LEN_W-1:0] pattern_length_ff, pattern_length_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_matched_ff, rsp_matched_in;
   logic                       rsp_busy;
   logic                       rsp_load;
   logic                       matched;

   // length register, always writable
   assign csr_ready         = 1'b1;
   assign pattern_length_in = (csr_valid && csr_ready) ? csr_pattern_length : pattern_length_ff;

   // output register: busy while a result is pending and not taken this cycle
   assign rsp_busy       = rsp_valid_ff && !rsp_ready;
   assign rsp_valid_in   = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign rsp_matched_in = rsp_load ? matched : rsp_matched_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         pattern_length_ff <= pattern_length_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_matched_ff <= rsp_matched_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;

   // sequencer: item decode and pass ordering
   dspm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_busy  (rsp_busy),
      .rsp_load  (rsp_load),
      .cmd       (cmd),
      .status    (status)
   );

   // pattern store and row sweep
   dspm_datapath #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .pattern_pos    (req_pattern_pos),
      .symbol         (req_symbol),
      .pattern_length (pattern_length_ff),
      .matched        (matched)
   );

endmodule

// ===== rtl/dspm_ctrl.sv =====
module dspm_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [dspm_pkg::REQ_W-1:0]   req_type,
   input  logic                         rsp_busy,
   output logic                         rsp_load,
   output dspm_pkg::cmd_type            cmd,
   input  dspm_pkg::status_type         status
);

   dspm_pkg::state_type state_ff, state_in;
   logic                started_ff, started_in;
   logic                then_sweep_ff, then_sweep_in;
   logic                accept;

   assign accept = req_valid && req_ready;

   // next state
   always_comb begin
      state_in      = state_ff;
      started_in    = started_ff;
      then_sweep_in = then_sweep_ff;
      case (state_ff)
         dspm_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (dspm_pkg::req_kind_type'(req_type))
                  dspm_pkg::REQ_BYTE: begin
                     state_in      = started_ff ? dspm_pkg::ST_SWEEP : dspm_pkg::ST_BUILD;
                     started_in    = 1'b1;
                     then_sweep_in = 1'b1;
                  end
                  dspm_pkg::REQ_END: begin
                     state_in      = started_ff ? dspm_pkg::ST_SCAN : dspm_pkg::ST_BUILD;
                     started_in    = 1'b0;
                     then_sweep_in = 1'b0;
                  end
                  default: begin
                     state_in = dspm_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         dspm_pkg::ST_BUILD: begin
            if (status.last_step) begin
               state_in = then_sweep_ff ? dspm_pkg::ST_SWEEP : dspm_pkg::ST_REPORT;
            end
         end
         dspm_pkg::ST_SWEEP: begin
            if (status.last_step) begin
               state_in = dspm_pkg::ST_IDLE;
            end
         end
         dspm_pkg::ST_SCAN: begin
            if (status.last_step) begin
               state_in = dspm_pkg::ST_REPORT;
            end
         end
         dspm_pkg::ST_REPORT: begin
            if (!rsp_busy) begin
               state_in = dspm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dspm_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = 1'b0;
      rsp_load      = 1'b0;
      cmd.step      = 1'b0;
      cmd.mode      = dspm_pkg::PASS_SCAN;
      cmd.wr_en     = 1'b0;
      cmd.load_byte = 1'b0;
      case (state_ff)
         dspm_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.wr_en     = req_valid &&
                            (dspm_pkg::req_kind_type'(req_type) == dspm_pkg::REQ_WRITE);
            cmd.load_byte = req_valid &&
                            (dspm_pkg::req_kind_type'(req_type) == dspm_pkg::REQ_BYTE);
         end
         dspm_pkg::ST_BUILD: begin
            cmd.step = 1'b1;
            cmd.mode = dspm_pkg::PASS_BUILD;
         end
         dspm_pkg::ST_SWEEP: begin
            cmd.step = 1'b1;
            cmd.mode = dspm_pkg::PASS_SWEEP;
         end
         dspm_pkg::ST_SCAN: begin
            cmd.step = 1'b1;
            cmd.mode = dspm_pkg::PASS_SCAN;
         end
         dspm_pkg::ST_REPORT: begin
            rsp_load = !rsp_busy;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dspm_pkg::ST_IDLE;
         started_ff    <= 1'b0;
         then_sweep_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         started_ff    <= started_in;
         then_sweep_ff <= then_sweep_in;
      end
   end

`ifndef SYNTH
   a_sweep_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dspm_pkg::ST_SWEEP && status.last_step)
      |=> (state_ff == dspm_pkg::ST_IDLE && started_ff))
      else $error("sweep pass did not return to idle with a subject open");

   a_end_closes_subject: assert property (@(posedge clock) disable iff (reset)
      (accept && dspm_pkg::req_kind_type'(req_type) == dspm_pkg::REQ_END)
      |=> (!started_ff && state_ff != dspm_pkg::ST_IDLE))
      else $error("end item left subject open");
`endif

endmodule

// ===== rtl/dspm_datapath.sv =====
module dspm_datapath #(
   parameter int MAX_PATTERN = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  dspm_pkg::cmd_type               cmd,
   output dspm_pkg::status_type            status,
   input  logic [dspm_pkg::POS_W-1:0]      pattern_pos,
   input  logic [dspm_pkg::SYMBOL_W-1:0]   symbol,
   input  logic [dspm_pkg::LEN_W-1:0]      pattern_length,
   output logic                            matched
);

   localparam int ADDR_W = $clog2(MAX_PATTERN);
   localparam int J_W    = $clog2(MAX_PATTERN + 1);
   localparam int CMP_W  = (J_W > dspm_pkg::LEN_W) ? J_W : dspm_pkg::LEN_W;

   // pattern symbols
   logic [dspm_pkg::SYMBOL_W-1:0] mem [MAX_PATTERN];
   logic [dspm_pkg::SYMBOL_W-1:0] rd_data_ff;
   logic [dspm_pkg::SYMBOL_W-1:0] sym_prev_ff;
   logic [dspm_pkg::SYMBOL_W-1:0] byte_ff;
   logic [ADDR_W-1:0]             rd_addr;
   logic [ADDR_W-1:0]             wr_addr;
   logic                          wr_ok;

   // row held as a rotating line, head is the oldest bit
   logic [MAX_PATTERN:0] row_ff, row_in;
   logic                 prev_last_ff;
   logic                 n1_ff;
   logic                 n2_ff;
   logic                 result_ff;

   logic [J_W-1:0]   j_ff, j_in;
   logic [CMP_W-1:0] j_ext, len_ext, max_ext, m_used;
   logic             in_range;
   logic             j_ge2;
   logic             last;
   logic             head;
   logic             new_bit;
   logic             p_star, p_hit, ps_hit;

   assign rd_addr = j_ff[ADDR_W-1:0];
   assign wr_addr = ADDR_W'(pattern_pos);
   assign wr_ok   = 32'(pattern_pos) < 32'(MAX_PATTERN);

   assign j_ext    = CMP_W'(j_ff);
   assign len_ext  = CMP_W'(pattern_length);
   assign max_ext  = CMP_W'(MAX_PATTERN);
   assign m_used   = (len_ext > max_ext) ? max_ext : len_ext;
   assign in_range = (j_ff != '0) && (j_ext <= m_used);
   assign j_ge2    = j_ff > J_W'(1);
   assign last     = j_ff == J_W'(MAX_PATTERN);
   assign head     = row_ff[0];

   assign p_star = rd_data_ff == dspm_pkg::SYM_STAR;
   assign p_hit  = (rd_data_ff == dspm_pkg::SYM_DOT) || (rd_data_ff == byte_ff);
   assign ps_hit = (sym_prev_ff == dspm_pkg::SYM_DOT) || (sym_prev_ff == byte_ff);

   always_comb begin
      new_bit = 1'b0;
      case (cmd.mode)
         dspm_pkg::PASS_BUILD: begin
            if (j_ff == '0) begin
               new_bit = 1'b1;
            end else if (in_range && p_star && j_ge2) begin
               new_bit = n2_ff;
            end
         end
         dspm_pkg::PASS_SWEEP: begin
            if (in_range) begin
               if (p_star) begin
                  new_bit = j_ge2 && (n2_ff || (ps_hit && head));
               end else if (p_hit) begin
                  new_bit = prev_last_ff;
               end
            end
         end
         dspm_pkg::PASS_SCAN: begin
            new_bit = head;
         end
         default: begin
            new_bit = 1'b0;
         end
      endcase
   end

   assign row_in = {new_bit, row_ff[MAX_PATTERN:1]};
   assign j_in   = last ? '0 : j_ff + J_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         j_ff <= '0;
      end else if (cmd.step) begin
         j_ff <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en && wr_ok) begin
         mem[wr_addr] <= symbol;
      end
      if (cmd.step) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_byte) begin
         byte_ff <= symbol;
      end
      if (cmd.step) begin
         row_ff       <= row_in;
         sym_prev_ff  <= rd_data_ff;
         prev_last_ff <= head;
         n1_ff        <= new_bit;
         n2_ff        <= n1_ff;
         if (j_ext == m_used) begin
            result_ff <= new_bit;
         end
      end
   end

   assign status.last_step = last;
   assign matched          = result_ff;

`ifndef SYNTH
   a_counter_wraps: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && last) |=> (j_ff == '0))
      else $error("position counter did not wrap after last step");

   a_build_seeds_one: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && cmd.mode == dspm_pkg::PASS_BUILD && j_ff == '0)
      |=> row_ff[MAX_PATTERN])
      else $error("empty-subject row did not start with a match");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int MAX_PATTERN = 64;
   // a first byte costs a rebuild plus a sweep, so two passes is the longest item
   localparam int DRAIN_CYCLES = 2 * (MAX_PATTERN + 1) + 20;
   localparam logic [dspm_pkg::SYMBOL_W-1:0] CHAR_A = 8'd97;
   localparam logic [dspm_pkg::SYMBOL_W-1:0] CHAR_B = 8'd98;
   localparam logic [dspm_pkg::SYMBOL_W-1:0] CHAR_X = 8'd120;
   localparam int ITEM_TARGET = 800;

   // predicts the match bit of every end item and checks the reports in order
   class match_scoreboard;
      logic [dspm_pkg::SYMBOL_W-1:0] pattern [MAX_PATTERN];
      bit [MAX_PATTERN:0]            row;
      bit [MAX_PATTERN:0]            prior_row;
      bit                            subject_open;
      bit [dspm_pkg::LEN_W-1:0]      length_reg;
      bit                            expected_q [$];
      int                            reports;
      int                            hits;
      int                            errors;

      function int used_length();
         return (length_reg > MAX_PATTERN) ? MAX_PATTERN : int'(length_reg);
      endfunction

      // row for the empty subject: only star chains can match nothing
      function void start_row();
         int m;
         m = used_length();
         row = '0;
         row[0] = 1'b1;
         for (int j = 2; j <= m; j++)
            if (pattern[j-1] == dspm_pkg::SYM_STAR) row[j] = row[j-2];
      endfunction

      // one subject byte, positions resolved in ascending order
      function void advance_row(logic [dspm_pkg::SYMBOL_W-1:0] c);
         int m;
         logic [dspm_pkg::SYMBOL_W-1:0] pj;
         logic [dspm_pkg::SYMBOL_W-1:0] lead;
         m = used_length();
         prior_row = row;
         row = '0;
         for (int j = 1; j <= m; j++) begin
            pj = pattern[j-1];
            if (pj == dspm_pkg::SYM_STAR) begin
               if (j >= 2) begin
                  lead = pattern[j-2];
                  row[j] = row[j-2] |
                           ((lead == dspm_pkg::SYM_DOT || lead == c) & prior_row[j]);
               end
            end else if (pj == dspm_pkg::SYM_DOT || pj == c) begin
               row[j] = prior_row[j-1];
            end
         end
      endfunction

      function void note_item(dspm_pkg::req_kind_type kind,
                              logic [dspm_pkg::POS_W-1:0] pos,
                              logic [dspm_pkg::SYMBOL_W-1:0] sym);
         case (kind)
            dspm_pkg::REQ_WRITE: pattern[pos] = sym;
            dspm_pkg::REQ_BYTE: begin
               if (!subject_open) begin
                  start_row();
                  subject_open = 1'b1;
               end
               advance_row(sym);
            end
            dspm_pkg::REQ_END: begin
               if (!subject_open) start_row();
               expected_q.push_back(row[used_length()]);
               subject_open = 1'b0;
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic got);
         bit want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected report, matched=%b", got);
            return;
         end
         want = expected_q.pop_front();
         reports++;
         if (got === 1'b1) hits++;
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("report %0d: expected matched=%0b, got %b", reports, want, got);
         end
      endfunction
   endclass

   // clock, reset and block inputs, all known from time zero
   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [dspm_pkg::REQ_W-1:0]    req_type = dspm_pkg::REQ_NONE;
   logic [dspm_pkg::POS_W-1:0]    req_pattern_pos = '0;
   logic [dspm_pkg::SYMBOL_W-1:0] req_symbol = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_matched;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [dspm_pkg::LEN_W-1:0]    csr_pattern_length = '0;

   match_scoreboard sb = new();

   // stimulus bookkeeping
   int                            src_idle_pct = 0;
   int                            snk_stall_pct = 0;
   int                            items_sent = 0;
   int                            ignored_sent = 0;
   int                            settings = 0;
   int                            cur_len = 0;
   logic [dspm_pkg::SYMBOL_W-1:0] pat_buf [MAX_PATTERN];

   dot_star_pattern_match_unit #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_pattern_pos    (req_pattern_pos),
      .req_symbol         (req_symbol),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_matched        (rsp_matched),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_pattern_length (csr_pattern_length)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stalls at random, redrawn each cycle
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= snk_stall_pct);
   end

   // every accepted report goes straight to the checker
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) sb.check_result(rsp_matched);
   end

   // one item on the request channel, with random idle cycles ahead of it
   task automatic send_item(dspm_pkg::req_kind_type kind,
                            logic [dspm_pkg::POS_W-1:0] pos,
                            logic [dspm_pkg::SYMBOL_W-1:0] sym);
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_pattern_pos <= pos;
      req_symbol      <= sym;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_item(kind, pos, sym);
      if (kind == dspm_pkg::REQ_NONE) ignored_sent++;
      else items_sent++;
   endtask

   // sender goes quiet until every owed report has come back
   task automatic hold_off();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   // length register only changes with the block idle
   task automatic write_length(logic [dspm_pkg::LEN_W-1:0] value);
      hold_off();
      // a byte may still be in its sweep after the last report
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid          <= 1'b1;
      csr_pattern_length <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.length_reg = value;
      cur_len = (value > MAX_PATTERN) ? MAX_PATTERN : int'(value);
      settings++;
   endtask

   // mostly well formed, with a rare stray star for leading and doubled stars
   function automatic logic [dspm_pkg::SYMBOL_W-1:0] pick_pattern_symbol(int i);
      int r;
      r = $urandom_range(99);
      if (r < 2) return dspm_pkg::SYM_STAR;
      if (i > 0 && pat_buf[i-1] != dspm_pkg::SYM_STAR && r < 28) return dspm_pkg::SYM_STAR;
      if (r < 45) return dspm_pkg::SYM_DOT;
      if (r < 49) return 8'($urandom_range(255));
      return 8'(CHAR_A + $urandom_range(0, 2));
   endfunction

   // small alphabet so that subjects hit the pattern often
   function automatic logic [dspm_pkg::SYMBOL_W-1:0] pick_subject_byte();
      if ($urandom_range(99) < 88) return 8'(CHAR_A + $urandom_range(0, 2));
      return 8'($urandom_range(255));
   endfunction

   task automatic load_pattern(int n);
      for (int i = 0; i < n; i++) begin
         pat_buf[i] = pick_pattern_symbol(i);
         send_item(dspm_pkg::REQ_WRITE, 6'(i), pat_buf[i]);
      end
   endtask

   // one subject: usually grown from the pattern, then perhaps damaged
   task automatic run_subject();
      logic [dspm_pkg::SYMBOL_W-1:0] bytes [$];
      logic [dspm_pkg::SYMBOL_W-1:0] sym;
      int i;
      int reps;
      int r;
      if ($urandom_range(99) < 85) begin
         i = 0;
         while (i < cur_len && bytes.size() < 16) begin
            sym = pat_buf[i];
            if (i + 1 < cur_len && pat_buf[i+1] == dspm_pkg::SYM_STAR &&
                sym != dspm_pkg::SYM_STAR) begin
               // repeated symbol, zero to three copies
               reps = $urandom_range(0, 3);
               repeat (reps)
                  bytes.push_back(sym == dspm_pkg::SYM_DOT ? pick_subject_byte() : sym);
               i += 2;
            end else if (sym == dspm_pkg::SYM_STAR) begin
               i++;
            end else begin
               bytes.push_back(sym == dspm_pkg::SYM_DOT ? pick_subject_byte() : sym);
               i++;
            end
         end
         if ($urandom_range(99) < 25 && bytes.size() > 0)
            bytes[$urandom_range(bytes.size() - 1)] = pick_subject_byte();
         if ($urandom_range(99) < 10) bytes.push_back(pick_subject_byte());
      end else begin
         repeat ($urandom_range(0, 6)) bytes.push_back(pick_subject_byte());
      end
      foreach (bytes[k]) begin
         r = $urandom_range(99);
         // noise: ignored kind, pattern rewrite mid subject, full drain
         if (r < 4)
            send_item(dspm_pkg::REQ_NONE, 6'($urandom_range(63)), 8'($urandom_range(255)));
         else if (r < 7)
            send_item(dspm_pkg::REQ_WRITE, 6'($urandom_range(63)), 8'($urandom_range(255)));
         else if (r < 9) hold_off();
         send_item(dspm_pkg::REQ_BYTE, 6'($urandom_range(63)), bytes[k]);
      end
      send_item(dspm_pkg::REQ_END, 6'($urandom_range(63)), 8'($urandom_range(255)));
   endtask

   initial begin
      int phase;
      int len;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty pattern: empty subject matches, any byte does not
      write_length('0);
      send_item(dspm_pkg::REQ_END, 6'd63, 8'hFF);
      send_item(dspm_pkg::REQ_BYTE, 6'd0, 8'hFF);
      send_item(dspm_pkg::REQ_END, 6'd0, 8'h00);
      send_item(dspm_pkg::REQ_NONE, 6'd63, 8'hFF);

      // star at position zero matches nothing, even a star byte
      send_item(dspm_pkg::REQ_WRITE, 6'd0, dspm_pkg::SYM_STAR);
      write_length(7'd1);
      send_item(dspm_pkg::REQ_END, 6'd0, 8'h00);
      send_item(dspm_pkg::REQ_BYTE, 6'd0, dspm_pkg::SYM_STAR);
      send_item(dspm_pkg::REQ_END, 6'd0, 8'h00);

      // doubled star repeats the star byte itself
      send_item(dspm_pkg::REQ_WRITE, 6'd0, CHAR_A);
      send_item(dspm_pkg::REQ_WRITE, 6'd1, dspm_pkg::SYM_STAR);
      send_item(dspm_pkg::REQ_WRITE, 6'd2, dspm_pkg::SYM_STAR);
      write_length(7'd3);
      send_item(dspm_pkg::REQ_BYTE, 6'd0, CHAR_A);
      send_item(dspm_pkg::REQ_BYTE, 6'd0, dspm_pkg::SYM_STAR);
      send_item(dspm_pkg::REQ_BYTE, 6'd0, dspm_pkg::SYM_STAR);
      send_item(dspm_pkg::REQ_END, 6'd0, 8'h00);

      // dot star, then the pattern changes under an open subject
      send_item(dspm_pkg::REQ_WRITE, 6'd0, dspm_pkg::SYM_DOT);
      send_item(dspm_pkg::REQ_WRITE, 6'd1, dspm_pkg::SYM_STAR);
      send_item(dspm_pkg::REQ_WRITE, 6'd2, CHAR_B);
      send_item(dspm_pkg::REQ_BYTE, 6'd0, CHAR_X);
      send_item(dspm_pkg::REQ_BYTE, 6'd0, CHAR_B);
      send_item(dspm_pkg::REQ_WRITE, 6'd2, CHAR_X);
      send_item(dspm_pkg::REQ_BYTE, 6'd0, CHAR_X);
      send_item(dspm_pkg::REQ_END, 6'd0, 8'h00);

      // random phases: full length first, then above the store size, then mixed
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         case (phase % 4)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 46; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 46; end
            default: begin src_idle_pct = 17; snk_stall_pct = 17; end
         endcase
         if (phase == 0) len = MAX_PATTERN;
         else if (phase == 1) len = 127;
         else if ($urandom_range(99) < 60) len = $urandom_range(0, 8);
         else if ($urandom_range(99) < 60) len = $urandom_range(9, 24);
         else if ($urandom_range(99) < 70) len = $urandom_range(25, MAX_PATTERN);
         else len = $urandom_range(MAX_PATTERN + 1, 127);
         write_length(7'(len));
         load_pattern(cur_len);
         repeat ($urandom_range(3, 8)) run_subject();
         phase++;
      end

      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d items plus %0d ignored ones over %0d length settings",
               items_sent, ignored_sent, settings);
      $display("%0d reports checked, %0d matching, %0d errors, %0d reports missing",
               sb.reports, sb.hits, sb.errors, sb.expected_q.size());
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("** dot_star_pattern_match_unit: PASSED **");
      else
         $display("** dot_star_pattern_match_unit: FAILED **");
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #10_000_000;
      $display("** dot_star_pattern_match_unit: FAILED **");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/dspm_pkg.sv
rtl/dspm_ctrl.sv
rtl/dspm_datapath.sv
rtl/dot_star_pattern_match_unit.sv
tb/testbench.sv
